FILE: src/remote_control_register_block_defines.svh
// Assertion macros shared by the remote control register block.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef REMOTE_CONTROL_REGISTER_BLOCK_DEFINES_SVH
`define REMOTE_CONTROL_REGISTER_BLOCK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RCRB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RCRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/rcrb_pkg.sv
// Shared types, constants and decode functions of the remote control register block.
// No dependencies.
`timescale 1ns / 1ps

package rcrb_pkg;

  localparam int REG_WORDS_DEF = 52;
  localparam int CHANNELS      = 4;
  localparam int INT_W         = 30;
  localparam int SIM_W         = 5;
  localparam int START_BIT     = 0;
  localparam int TX_DONE_BIT   = 7;

  localparam logic       OP_READ     = 1'b0;
  localparam logic       OP_WRITE    = 1'b1;
  localparam logic [3:0] ACCESS_WORD = 4'd4;

  localparam logic [11:0] ADDR_RAW    = 12'h070;
  localparam logic [11:0] ADDR_STATUS = 12'h074;
  localparam logic [11:0] ADDR_ENA    = 12'h078;
  localparam logic [11:0] ADDR_CLR    = 12'h07C;
  localparam logic [11:0] ADDR_SYS    = 12'h0C0;
  localparam logic [11:0] ADDR_SIM    = 12'h0C4;
  localparam logic [11:0] ADDR_CNT    = 12'h0C8;
  localparam logic [11:0] ADDR_DATE   = 12'h0CC;
  localparam logic [11:0] WINDOW_END  = 12'h0D0;

  typedef struct packed {
    logic        operation;
    logic [11:0] address;
    logic [3:0]  access_size;
    logic [31:0] write_data;
  } rcrb_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
  } rcrb_rsp_t;

  // Write mask of the words held in the RAM. Interrupt, sim and status words are
  // handled elsewhere or read-only, so they give an empty mask here.
  function automatic logic [31:0] rcrb_write_mask(logic [11:0] addr);
    logic [31:0] m;
    m = 32'h0;
    case (addr) inside
      [12'h000:12'h01F]: m = 32'hFFFF_FFFF;
      [12'h020:12'h02F]: m = 32'h007F_FFF8;
      [12'h030:12'h04F]: m = addr[2] ? 32'h0000_3FF9 : 32'h3F7F_FFFF;
      [12'h080:12'h09F]: m = 32'hFFFF_FFFF;
      [12'h0A0:12'h0AF]: m = 32'h002F_FFFF;
      [12'h0B0:12'h0BF]: m = 32'h0000_01FF;
      ADDR_SYS:          m = 32'h87FF_FFFF;
      ADDR_DATE:         m = 32'h0FFF_FFFF;
      default:           m = 32'h0;
    endcase
    return m;
  endfunction

  // Value of a RAM word that has not been written since reset.
  function automatic logic [31:0] rcrb_reset_word(logic [7:0] waddr);
    logic [31:0] w;
    w = 32'h0;
    case (waddr) inside
      [8'h20:8'h2F]: w = 32'h0071_0200;
      [8'h30:8'h4F]: w = waddr[2] ? 32'h0000_01E8 : 32'h3100_7F02;
      [8'h60:8'h6F]: w = 32'h0006_00C0;
      [8'h80:8'h8F]: w = 32'h0040_0040;
      [8'hA0:8'hBF]: w = 32'h0000_0080;
      8'hC0:         w = 32'h0500_0010;
      8'hCC:         w = 32'h0210_1181;
      default:       w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

FILE: src/rcrb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module rcrb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 52,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/remote_control_register_block.sv
// Top level of the remote control register block: bus decode, interrupt registers, output stage.
// Depends on rcrb_pkg, rcrb_ram and remote_control_register_block_defines.svh.
//
//   Channel | Ports                          | Carries
//   --------+--------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_data    | one bus access request
//   out     | out_valid, out_stall, out_data | read data and interrupt level
//
// One request is taken every cycle while in_stall is low; its result passes through the
// registered RAM read or the middle-stage register, and then through the output register.
// Reset clears the interrupt registers and the written flags, so every word reads its default.
// A stalled output holds its result while one more request is taken into the middle stage.
`timescale 1ns / 1ps
`include "remote_control_register_block_defines.svh"

module remote_control_register_block #(
  parameter int REG_WORDS = rcrb_pkg::REG_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rcrb_pkg::rcrb_req_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rcrb_pkg::rcrb_rsp_t out_data
);

  localparam int IDX_W = $clog2(REG_WORDS);

  typedef struct packed {
    logic             from_ram;
    logic             ent_valid;
    logic [IDX_W-1:0] idx;
    logic [31:0]      word;
    logic             irq;
  } s1_t;

  logic [rcrb_pkg::CHANNELS-1:0] raw_r, raw_nxt;
  logic [rcrb_pkg::INT_W-1:0]    ena_r, ena_nxt;
  logic [rcrb_pkg::SIM_W-1:0]    sim_r, sim_nxt;
  logic [REG_WORDS-1:0]          valid_r, valid_nxt;
  logic                          s1_valid_r, s1_valid_nxt;
  s1_t                           s1_r, s1_nxt;
  logic                          out_valid_r, out_valid_nxt;
  rcrb_pkg::rcrb_rsp_t           out_data_r, out_data_nxt;

  logic                          out_adv;
  logic                          acc;
  logic                          is_word;
  logic                          wr_acc;
  logic                          rd_acc;
  logic [31:0]                   wmask;
  logic [31:0]                   wdata;
  logic                          start_go;
  logic                          ram_we;
  logic                          ram_re;
  logic [IDX_W-1:0]              idx;
  logic [rcrb_pkg::CHANNELS-1:0] set_bits;
  logic [31:0]                   ram_q;

  // Handshake: the middle stage drains whenever the output register can take it.
  assign out_adv  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_adv;
  assign acc      = in_valid && !in_stall;

  assign is_word = (in_data.access_size == rcrb_pkg::ACCESS_WORD);
  assign wr_acc  = acc && is_word && (in_data.operation == rcrb_pkg::OP_WRITE);
  assign rd_acc  = acc && is_word && (in_data.operation == rcrb_pkg::OP_READ);
  assign idx     = in_data.address[IDX_W+1:2];

  // Channel config words sit at 0x20..0x2F; a start bit there fires a transmit.
  assign wmask    = rcrb_pkg::rcrb_write_mask(in_data.address);
  assign start_go = (in_data.address[11:4] == 8'h02) &&
                    in_data.write_data[rcrb_pkg::START_BIT];
  assign ram_we   = wr_acc && (wmask != 32'h0);

  always_comb begin
    wdata = in_data.write_data & wmask;
    if (start_go) begin
      wdata[rcrb_pkg::TX_DONE_BIT] = 1'b0;
    end
  end

  always_comb begin
    set_bits = rcrb_pkg::CHANNELS'(1) << in_data.address[3:2];
    if (sim_r[rcrb_pkg::SIM_W-1]) begin
      set_bits = set_bits | sim_r[rcrb_pkg::CHANNELS-1:0];
    end
  end

  always_comb begin
    raw_nxt   = raw_r;
    ena_nxt   = ena_r;
    sim_nxt   = sim_r;
    valid_nxt = valid_r;
    if (wr_acc) begin
      if (in_data.address == rcrb_pkg::ADDR_RAW || in_data.address == rcrb_pkg::ADDR_CLR) begin
        raw_nxt = raw_r & ~in_data.write_data[rcrb_pkg::CHANNELS-1:0];
      end else if (in_data.address == rcrb_pkg::ADDR_ENA) begin
        ena_nxt = in_data.write_data[rcrb_pkg::INT_W-1:0];
      end else if (in_data.address == rcrb_pkg::ADDR_SIM) begin
        sim_nxt = in_data.write_data[rcrb_pkg::SIM_W-1:0];
      end else if (ram_we && start_go) begin
        raw_nxt = raw_r | set_bits;
      end
    end
    if (ram_we) begin
      valid_nxt[idx] = 1'b1;
    end
  end

  // Read decode. Words kept in flip-flops are captured now; the rest comes from the RAM.
  always_comb begin
    s1_nxt.from_ram  = 1'b0;
    s1_nxt.ent_valid = valid_r[idx];
    s1_nxt.idx       = idx;
    s1_nxt.word      = 32'h0;
    s1_nxt.irq       = |(raw_nxt & ena_nxt[rcrb_pkg::CHANNELS-1:0]);
    if (rd_acc) begin
      if (in_data.address == rcrb_pkg::ADDR_STATUS) begin
        s1_nxt.word = 32'(raw_r & ena_r[rcrb_pkg::CHANNELS-1:0]);
      end else if (in_data.address == rcrb_pkg::ADDR_CLR ||
                   in_data.address == rcrb_pkg::ADDR_CNT) begin
        s1_nxt.word = 32'h0;
      end else if (in_data.address < rcrb_pkg::WINDOW_END) begin
        if (in_data.address[11:2] == rcrb_pkg::ADDR_RAW[11:2]) begin
          s1_nxt.word = 32'(raw_r);
        end else if (in_data.address[11:2] == rcrb_pkg::ADDR_ENA[11:2]) begin
          s1_nxt.word = 32'(ena_r);
        end else if (in_data.address[11:2] == rcrb_pkg::ADDR_SIM[11:2]) begin
          s1_nxt.word = 32'(sim_r);
        end else begin
          s1_nxt.from_ram = 1'b1;
        end
      end
    end
  end

  assign ram_re = rd_acc && s1_nxt.from_ram;

  rcrb_ram #(
    .WIDTH (32),
    .DEPTH (REG_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx),
    .wr_data (wdata),
    .rd_en   (ram_re),
    .rd_addr (idx),
    .rd_data (ram_q)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = 1'b1;
    end else if (out_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_adv && s1_valid_r) begin
      out_data_nxt.irq_level = s1_r.irq;
      if (!s1_r.from_ram) begin
        out_data_nxt.read_data = s1_r.word;
      end else if (s1_r.ent_valid) begin
        out_data_nxt.read_data = ram_q;
      end else begin
        out_data_nxt.read_data = rcrb_pkg::rcrb_reset_word(8'({s1_r.idx, 2'b00}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r       <= '0;
      ena_r       <= '0;
      sim_r       <= '0;
      valid_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      raw_r       <= raw_nxt;
      ena_r       <= ena_nxt;
      sim_r       <= sim_nxt;
      valid_r     <= valid_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RCRB_ASSERT_NEXT(a_raw_set_only_by_start, !(wr_acc && start_go), (raw_r & ~$past(raw_r)) == '0, "raw interrupt bit set without a transmit start")
  `RCRB_ASSERT_NEXT(a_ram_read_lands_in_s1, ram_re, s1_valid_r && s1_r.from_ram, "RAM read issued but middle stage does not expect it")
  `RCRB_ASSERT_SAME(a_stall_only_when_full, in_stall, s1_valid_r && out_valid_r, "input stalled while the pipeline has room")

endmodule

FILE: test/rcrb_monitor.sv
// Response checker for the remote control register block: watches both handshakes,
// keeps its own copy of the register file and compares every returned response.
// Depends on rcrb_pkg for the request and response types and the address map.
`timescale 1ns / 1ps

module rcrb_monitor
  import rcrb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  rcrb_req_t in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  rcrb_rsp_t out_data,
  output int        fail_count,
  output int        outstanding,
  output int        results_checked,
  output int        irq_results
);

  localparam int NUM_WORDS   = REG_WORDS_DEF;
  localparam int SYNC_EN_BIT = SIM_W - 1;

  localparam logic [11:0] CHN_CONF_BASE = 12'h020;
  localparam logic [11:0] CHM_CONF_BASE = 12'h030;
  localparam logic [11:0] CHM_STAT_BASE = 12'h050;
  localparam logic [11:0] CARRIER_BASE  = 12'h080;
  localparam logic [11:0] TX_LIM_BASE   = 12'h0A0;
  localparam logic [11:0] RX_LIM_BASE   = 12'h0B0;
  localparam logic [11:0] RX_LIM_END    = 12'h0C0;

  localparam logic [31:0] INT_MASK       = 32'h3FFF_FFFF;
  localparam logic [31:0] MASK_CHN_CONF  = 32'h007F_FFF8;
  localparam logic [31:0] MASK_CHM_CONF0 = 32'h3F7F_FFFF;
  localparam logic [31:0] MASK_CHM_CONF1 = 32'h0000_3FF9;
  localparam logic [31:0] MASK_TX_LIM    = 32'h002F_FFFF;
  localparam logic [31:0] MASK_RX_LIM    = 32'h0000_01FF;
  localparam logic [31:0] MASK_SYS       = 32'h87FF_FFFF;
  localparam logic [31:0] MASK_SIM       = 32'h0000_001F;
  localparam logic [31:0] MASK_DATE      = 32'h0FFF_FFFF;

  localparam logic [31:0] RST_CHN_CONF   = 32'h0071_0200;
  localparam logic [31:0] RST_CHM_CONF0  = 32'h3100_7F02;
  localparam logic [31:0] RST_CHM_CONF1  = 32'h0000_01E8;
  localparam logic [31:0] RST_CHM_STATUS = 32'h0006_00C0;
  localparam logic [31:0] RST_CARRIER    = 32'h0040_0040;
  localparam logic [31:0] RST_LIMIT      = 32'h0000_0080;
  localparam logic [31:0] RST_SYS        = 32'h0500_0010;
  localparam logic [31:0] RST_DATE       = 32'h0210_1181;

  localparam int RAW_IDX = ADDR_RAW >> 2;
  localparam int ENA_IDX = ADDR_ENA >> 2;
  localparam int SIM_IDX = ADDR_SIM >> 2;

  logic [31:0] regfile [NUM_WORDS];
  rcrb_rsp_t   expected_rsp [$];

  // Applies one request to the register file copy and returns the response it should give.
  function automatic rcrb_rsp_t apply_access(rcrb_req_t r);
    rcrb_rsp_t   rsp;
    logic [11:0] a;
    logic [31:0] v;
    logic [31:0] m;
    logic [31:0] setbits;
    int          idx;
    a = r.address;
    v = r.write_data;
    idx = a >> 2;
    rsp.read_data = '0;
    if (r.access_size == ACCESS_WORD) begin
      if (r.operation == OP_READ) begin
        if (a == ADDR_STATUS) begin
          rsp.read_data = regfile[RAW_IDX] & regfile[ENA_IDX];
        end else if (a == ADDR_CLR || a == ADDR_CNT) begin
          rsp.read_data = '0;
        end else if (a < WINDOW_END) begin
          rsp.read_data = regfile[idx];
        end
      end else if (a == ADDR_RAW || a == ADDR_CLR) begin
        regfile[RAW_IDX] = regfile[RAW_IDX] & ~(v & INT_MASK);
      end else if (a == ADDR_ENA) begin
        regfile[ENA_IDX] = v & INT_MASK;
      end else if (a != ADDR_CNT && !(a >= CHM_STAT_BASE && a < ADDR_RAW) && a < WINDOW_END) begin
        // Ranged words decode on address/4; the single words only at their exact offset.
        if (a < CHN_CONF_BASE) m = '1;
        else if (a < CHM_CONF_BASE) m = MASK_CHN_CONF;
        else if (a < CHM_STAT_BASE) m = a[2] ? MASK_CHM_CONF1 : MASK_CHM_CONF0;
        else if (a >= CARRIER_BASE && a < TX_LIM_BASE) m = '1;
        else if (a >= TX_LIM_BASE && a < RX_LIM_BASE) m = MASK_TX_LIM;
        else if (a >= RX_LIM_BASE && a < RX_LIM_END) m = MASK_RX_LIM;
        else if (a == ADDR_SYS) m = MASK_SYS;
        else if (a == ADDR_SIM) m = MASK_SIM;
        else if (a == ADDR_DATE) m = MASK_DATE;
        else m = '0;
        if (m != '0) begin
          regfile[idx] = v & m;
          if (a >= CHN_CONF_BASE && a < CHM_CONF_BASE && v[START_BIT]) begin
            // A transmit start clears the done bit and raises the channel's raw bit,
            // plus every channel in the sync mask when sync mode is on.
            regfile[idx][TX_DONE_BIT] = 1'b0;
            setbits = '0;
            setbits[a[3:2]] = 1'b1;
            if (regfile[SIM_IDX][SYNC_EN_BIT]) setbits[3:0] = setbits[3:0] | regfile[SIM_IDX][3:0];
            regfile[RAW_IDX][3:0] = regfile[RAW_IDX][3:0] | setbits[3:0];
          end
        end
      end
    end
    rsp.irq_level = |(regfile[RAW_IDX] & regfile[ENA_IDX]);
    return rsp;
  endfunction

  always @(posedge clk) begin
    rcrb_rsp_t want;
    int        errs;
    int        i;
    errs = 0;
    if (!rst_n) begin
      for (i = 0; i < NUM_WORDS; i++) regfile[i] = '0;
      for (i = 0; i < CHANNELS; i++) begin
        regfile[(CHN_CONF_BASE >> 2) + i]         = RST_CHN_CONF;
        regfile[(CHM_CONF_BASE >> 2) + 2 * i]     = RST_CHM_CONF0;
        regfile[(CHM_CONF_BASE >> 2) + 2 * i + 1] = RST_CHM_CONF1;
        regfile[(12'h060 >> 2) + i]               = RST_CHM_STATUS;
        regfile[(CARRIER_BASE >> 2) + i]          = RST_CARRIER;
        regfile[(TX_LIM_BASE >> 2) + i]           = RST_LIMIT;
        regfile[(RX_LIM_BASE >> 2) + i]           = RST_LIMIT;
      end
      regfile[ADDR_SYS >> 2]  = RST_SYS;
      regfile[ADDR_DATE >> 2] = RST_DATE;
      expected_rsp.delete();
    end else begin
      if (in_valid && !in_stall) expected_rsp.push_back(apply_access(in_data));
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          $error("response with no request waiting: read_data %h irq_level %b",
                 out_data.read_data, out_data.irq_level);
          errs++;
        end else begin
          want = expected_rsp.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data mismatch: expected %h, got %h", want.read_data, out_data.read_data);
            errs++;
          end
          if (out_data.irq_level !== want.irq_level) begin
            $error("irq_level mismatch: expected %b, got %b", want.irq_level, out_data.irq_level);
            errs++;
          end
          results_checked <= results_checked + 1;
          if (want.irq_level) irq_results <= irq_results + 1;
        end
      end
    end
    fail_count  <= fail_count + errs;
    outstanding <= expected_rsp.size();
  end

endmodule

FILE: test/tb_remote_control_register_block.sv
// Testbench top for the remote control register block: clock, reset, request stimulus,
// response stall pattern, watchdog and verdict. Depends on rcrb_pkg and rcrb_monitor.
`timescale 1ns / 1ps

module tb_remote_control_register_block;
  import rcrb_pkg::*;

  localparam int QUIET_LIMIT      = 1000;
  localparam int RANDOM_PER_PHASE = 200;
  localparam int DRAIN_CYCLES     = 8;

  localparam logic [11:0] CHN_CONF_BASE = 12'h020;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  rcrb_req_t in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rcrb_rsp_t out_data;

  int fail_count;
  int outstanding;
  int results_checked;
  int irq_results;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int quiet_cycles = 0;

  remote_control_register_block dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  rcrb_monitor u_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .irq_results     (irq_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic rcrb_req_t bus_access(logic op, logic [11:0] addr, logic [3:0] size,
                                           logic [31:0] data);
    rcrb_req_t r;
    r.operation   = op;
    r.address     = addr;
    r.access_size = size;
    r.write_data  = data;
    return r;
  endfunction

  // Mostly word accesses to the register window, weighted toward the interrupt and
  // channel config words, with some unaligned, out-of-window and odd-size noise.
  function automatic rcrb_req_t random_request();
    rcrb_req_t r;
    int        pick;
    r.operation = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.address = 12'($urandom_range(0, REG_WORDS_DEF - 1) * 4);
    end else if (pick < 80) begin
      case ($urandom_range(0, 9))
        0: r.address = CHN_CONF_BASE;
        1: r.address = CHN_CONF_BASE + 12'h4;
        2: r.address = CHN_CONF_BASE + 12'h8;
        3: r.address = CHN_CONF_BASE + 12'hC;
        4: r.address = ADDR_RAW;
        5: r.address = ADDR_STATUS;
        6: r.address = ADDR_ENA;
        7: r.address = ADDR_CLR;
        8: r.address = ADDR_SIM;
        default: r.address = ADDR_CNT;
      endcase
    end else if (pick < 90) begin
      r.address = 12'($urandom_range(0, WINDOW_END - 1));
    end else begin
      r.address = 12'($urandom());
    end
    r.access_size = ($urandom_range(0, 99) < 88) ? ACCESS_WORD : 4'($urandom_range(1, 8));
    pick = $urandom_range(0, 99);
    if (pick < 10) r.write_data = '1;
    else if (pick < 20) r.write_data = '0;
    else if (pick < 30) r.write_data = 32'(1) << $urandom_range(0, 31);
    else r.write_data = $urandom();
    return r;
  endfunction

  task automatic send_request(input rcrb_req_t req);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic write_word(input logic [11:0] addr, input logic [31:0] data);
    send_request(bus_access(OP_WRITE, addr, ACCESS_WORD, data));
  endtask

  task automatic read_word(input logic [11:0] addr);
    send_request(bus_access(OP_READ, addr, ACCESS_WORD, $urandom()));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 7;
    stall_pct    = 54;

    // Reset defaults, full-range data, sync start and interrupt clearing.
    read_word(ADDR_DATE);
    read_word(CHN_CONF_BASE);
    write_word(12'h000, 32'hFFFF_FFFF);
    read_word(12'h000);
    write_word(ADDR_ENA, 32'hFFFF_FFFF);
    write_word(ADDR_SIM, 32'h0000_001F);
    write_word(CHN_CONF_BASE + 12'h4, 32'hFFFF_FFFF);
    read_word(CHN_CONF_BASE + 12'h4);
    read_word(ADDR_RAW);
    read_word(ADDR_STATUS);
    write_word(ADDR_CLR, 32'hFFFF_FFFF);
    write_word(ADDR_SIM, 32'h0000_0000);
    write_word(CHN_CONF_BASE + 12'hC, 32'h0000_0001);
    write_word(ADDR_RAW, 32'h0000_0008);
    read_word(ADDR_CLR);
    read_word(ADDR_CNT);
    // Read-only words, odd access sizes, unaligned and out-of-window offsets.
    write_word(12'h060, 32'hFFFF_FFFF);
    read_word(12'h060);
    write_word(ADDR_STATUS, 32'hFFFF_FFFF);
    send_request(bus_access(OP_WRITE, 12'h000, 4'd8, 32'h0000_0000));
    send_request(bus_access(OP_READ, 12'h000, 4'd1, 32'h0000_0000));
    read_word(12'h072);
    write_word(12'h0C1, 32'hFFFF_FFFF);
    read_word(12'hFFF);
    read_word(WINDOW_END);

    repeat (RANDOM_PER_PHASE) send_request(random_request());
    send_gap_pct = 54;
    stall_pct    = 7;
    repeat (RANDOM_PER_PHASE) send_request(random_request());
    send_gap_pct = 0;
    stall_pct    = 0;
    repeat (RANDOM_PER_PHASE) send_request(random_request());
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Issued %0d requests under three pacing mixes; %0d responses compared.",
             requests_sent, results_checked);
    $display("The interrupt line was expected high on %0d of them.", irq_results);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: remote_control_register_block.f
+incdir+src
src/rcrb_pkg.sv
src/rcrb_ram.sv
src/remote_control_register_block.sv
test/rcrb_monitor.sv
test/tb_remote_control_register_block.sv
